>>> sv/pressure_profile_setpoint_generator_unit_defines.svh
// Assertion macros used by the checker file of the setpoint generator.
`ifndef PRESSURE_PROFILE_SETPOINT_GENERATOR_UNIT_DEFINES_SVH
`define PRESSURE_PROFILE_SETPOINT_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPSG_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPSG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ppsg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the setpoint generator.
package ppsg_pkg;

  localparam int SINE_TABLE_BITS = 8;
  localparam int QTAB_LEN        = (1 << SINE_TABLE_BITS) + 1;
  localparam int SIDX_W          = SINE_TABLE_BITS + 1;
  localparam int CFG_AW          = 5;
  localparam int DIV_DVD_W       = 47;
  localparam int DIV_CNT_W       = $clog2(DIV_DVD_W + 1);
  localparam int SAT_W           = 48;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] MODE_SINE  = 2'd0;
  localparam logic [1:0] MODE_TRAP  = 2'd1;
  localparam logic [1:0] MODE_LEVEL = 2'd2;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_RUN_LEN   = 3'd1,
    REG_AMPLITUDE = 3'd2,
    REG_PHASE     = 3'd3,
    REG_LEVEL     = 3'd4,
    REG_PEAK      = 3'd5,
    REG_RAMP      = 3'd6,
    REG_HOLD      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [1:0]  mode;
    logic        [31:0] run_len;
    logic signed [15:0] amp;
    logic        [31:0] phase_step;
    logic signed [15:0] level;
    logic        [14:0] peak;
    logic        [31:0] ramp;
    logic        [31:0] hold;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PHASE,
    ST_LOOKUP,
    ST_AMP,
    ST_SINE_SUM,
    ST_TRAP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WRITE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    RES_FIN,
    RES_NONE,
    RES_LEVEL,
    RES_PEAK,
    RES_SINE,
    RES_TRAP
  } res_sel_t;

  typedef struct packed {
    logic     start_load;
    logic     sample_load;
    logic     phase_mul;
    logic     lookup;
    logic     amp_mul;
    logic     trap_mul;
    logic     div_start;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       fin;
    logic [1:0] mode;
    logic       trap_flat;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

  typedef logic [15:0] stab_t [QTAB_LEN];

  function automatic stab_t build_stab();
    stab_t              t;
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] r;
    for (int i = 0; i < QTAB_LEN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      r = ($unsigned(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      t[i] = r[15:0];
    end
    return t;
  endfunction

  localparam stab_t SINE_TAB = build_stab();

endpackage

>>> sv/pressure_profile_setpoint_generator_unit.sv
// Top level of the timed pressure setpoint generator.
// A start item (tuser 0) latches now_ms and produces no result. A sample item (tuser 1)
// takes one result slot. Sine samples pass accept, decide, phase multiply, table lookup,
// amplitude multiply, offset and saturate, and output load; finished, static-level and
// spare-mode samples pass accept, decide and output load; trapezoid samples add a plateau
// test and, on the ramps, the restoring divider (a load step, then one shift per dividend
// bit) that forms peak * t / ramp_ms. One sample is in flight at a time; a new item is
// taken while the previous result still waits in the output register. Registers sit at
// byte address 4*index on the APB port and may be written only while the block is idle.
module pressure_profile_setpoint_generator_unit import ppsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] now_ms
  input  logic              in_tuser,   // [0] action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [15:0] target
  output logic              out_tuser,  // [0] finished
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ppsg_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  ppsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppsg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_now     (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_target (out_tdata),
    .out_fin    (out_tuser)
  );

endmodule

>>> sv/ppsg_cfg.sv
// Configuration register file with its APB-style access port.
module ppsg_cfg import ppsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_LEVEL;
      cfg_r.run_len    <= '0;
      cfg_r.amp        <= '0;
      cfg_r.phase_step <= '0;
      cfg_r.level      <= '0;
      cfg_r.peak       <= '0;
      cfg_r.ramp       <= '0;
      cfg_r.hold       <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:      cfg_r.mode       <= cfg_pwdata[1:0];
        REG_RUN_LEN:   cfg_r.run_len    <= cfg_pwdata;
        REG_AMPLITUDE: cfg_r.amp        <= $signed(cfg_pwdata[15:0]);
        REG_PHASE:     cfg_r.phase_step <= cfg_pwdata;
        REG_LEVEL:     cfg_r.level      <= $signed(cfg_pwdata[15:0]);
        REG_PEAK:      cfg_r.peak       <= cfg_pwdata[14:0];
        REG_RAMP:      cfg_r.ramp       <= cfg_pwdata;
        REG_HOLD:      cfg_r.hold       <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:      cfg_prdata = {30'd0, cfg_r.mode};
      REG_RUN_LEN:   cfg_prdata = cfg_r.run_len;
      REG_AMPLITUDE: cfg_prdata = {16'd0, cfg_r.amp};
      REG_PHASE:     cfg_prdata = cfg_r.phase_step;
      REG_LEVEL:     cfg_prdata = {16'd0, cfg_r.level};
      REG_PEAK:      cfg_prdata = {17'd0, cfg_r.peak};
      REG_RAMP:      cfg_prdata = cfg_r.ramp;
      REG_HOLD:      cfg_prdata = cfg_r.hold;
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

>>> sv/ppsg_div.sv
// Restoring divider, one quotient bit per cycle.
module ppsg_div import ppsg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [31:0]          divisor,
  output logic [DIV_DVD_W-1:0] quot,
  output logic                 done
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [31:0]          rem_r;
  logic [DIV_DVD_W-1:0] q_r;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic [32:0]          rem_sub;

  assign rem_sh  = {rem_r, q_r[DIV_DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quot    = q_r;
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_CNT_W'(DIV_DVD_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      q_r   <= {q_r[DIV_DVD_W-2:0], ge};
    end
  end

endmodule

>>> sv/ppsg_dp.sv
// Datapath: run timing, sine and trapezoid arithmetic, result and output registers.
module ppsg_dp import ppsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg_i,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_target,
  output logic        out_fin
);

  function automatic logic [15:0] sat16(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(32767)) begin
      return 16'h7FFF;
    end else if (v < -SAT_W'(32768)) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

  logic                 [31:0] start_time_r;
  logic                        done_r;
  logic                 [31:0] elapsed_r;
  logic                 [31:0] phase_r;
  logic signed          [16:0] s_r;
  logic signed          [32:0] sprod_r;
  logic       [DIV_DVD_W-1:0] tprod_r;
  logic                 [15:0] res_target_r;
  logic                        res_fin_r;
  logic                        out_valid_r;
  logic                 [15:0] out_target_r;
  logic                        out_fin_r;

  logic                 [32:0] edge_sum;
  logic                 [32:0] fall_d;
  logic                        rising;
  logic                        plateau;
  logic                 [31:0] factor;
  logic                  [1:0] quad;
  logic  [SINE_TABLE_BITS-1:0] idx_raw;
  logic           [SIDX_W-1:0] idx;
  logic signed          [16:0] tab_val;
  logic signed          [33:0] rnd;
  logic signed          [18:0] scaled;
  logic signed     [SAT_W-1:0] sine_sum;
  logic       [DIV_DVD_W-1:0] quot;
  logic signed     [SAT_W-1:0] trap_val;
  logic                        div_done;
  logic                 [15:0] res_target_nxt;

  assign edge_sum = {1'b0, cfg_i.ramp} + {1'b0, cfg_i.hold};
  assign fall_d   = {1'b0, elapsed_r} - edge_sum;
  assign rising   = elapsed_r < cfg_i.ramp;
  assign plateau  = {1'b0, elapsed_r} < edge_sum;
  assign factor   = rising ? elapsed_r : fall_d[31:0];

  assign quad    = phase_r[31:30];
  assign idx_raw = phase_r[29 -: SINE_TABLE_BITS];
  assign idx     = quad[0] ? (SIDX_W'(QTAB_LEN - 1) - {1'b0, idx_raw}) : {1'b0, idx_raw};
  assign tab_val = $signed({1'b0, SINE_TAB[idx]});

  assign rnd      = 34'(sprod_r) + 34'sd16384;
  assign scaled   = 19'(rnd >>> 15);
  assign sine_sum = SAT_W'(scaled) + SAT_W'(cfg_i.level);
  assign trap_val = $signed({33'd0, cfg_i.peak}) - $signed({1'b0, quot});

  ppsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tprod_r),
    .divisor  (cfg_i.ramp),
    .quot     (quot),
    .done     (div_done)
  );

  always_comb begin
    stat.fin       = done_r | (elapsed_r >= cfg_i.run_len);
    stat.mode      = cfg_i.mode;
    stat.trap_flat = !rising && (plateau || (cfg_i.ramp == '0));
    stat.div_done  = div_done;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= '0;
      done_r       <= 1'b1;
    end else if (cmd.start_load) begin
      start_time_r <= in_now;
      done_r       <= 1'b0;
    end else if (cmd.res_load && cmd.res_sel == RES_FIN) begin
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_load) begin
      elapsed_r <= in_now - start_time_r;
    end
    if (cmd.phase_mul) begin
      phase_r <= cfg_i.phase_step * elapsed_r;
    end
    if (cmd.lookup) begin
      s_r <= quad[1] ? -tab_val : tab_val;
    end
    if (cmd.amp_mul) begin
      sprod_r <= cfg_i.amp * s_r;
    end
    if (cmd.trap_mul) begin
      tprod_r <= DIV_DVD_W'(cfg_i.peak) * DIV_DVD_W'(factor);
    end
  end

  always_comb begin
    case (cmd.res_sel)
      RES_FIN:   res_target_nxt = '0;
      RES_NONE:  res_target_nxt = '0;
      RES_LEVEL: res_target_nxt = cfg_i.level;
      RES_PEAK:  res_target_nxt = {1'b0, cfg_i.peak};
      RES_SINE:  res_target_nxt = sat16(sine_sum);
      RES_TRAP:  res_target_nxt = rising ? quot[15:0] : sat16(trap_val);
      default:   res_target_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_target_r <= res_target_nxt;
      res_fin_r    <= (cmd.res_sel == RES_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_target_r <= res_target_r;
      out_fin_r    <= res_fin_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_target = out_target_r;
  assign out_fin    = out_fin_r;

endmodule

>>> sv/ppsg_ctrl.sv
// Controller: sequences one item at a time through the datapath.
module ppsg_ctrl import ppsg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_SAMPLE) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.fin) begin
          state_nxt = ST_WRITE;
        end else begin
          case (stat.mode)
            MODE_SINE: state_nxt = ST_PHASE;
            MODE_TRAP: state_nxt = ST_TRAP;
            default:   state_nxt = ST_WRITE;
          endcase
        end
      end
      ST_PHASE:     state_nxt = ST_LOOKUP;
      ST_LOOKUP:    state_nxt = ST_AMP;
      ST_AMP:       state_nxt = ST_SINE_SUM;
      ST_SINE_SUM:  state_nxt = ST_WRITE;
      ST_TRAP:      state_nxt = stat.trap_flat ? ST_WRITE : ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_sel = RES_NONE;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.start_load  = in_valid && in_action == ACT_START;
        cmd.sample_load = in_valid && in_action == ACT_SAMPLE;
      end
      ST_DECIDE: begin
        if (stat.fin) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FIN;
        end else begin
          case (stat.mode)
            MODE_SINE: begin
            end
            MODE_TRAP: begin
            end
            MODE_LEVEL: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_LEVEL;
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_NONE;
            end
          endcase
        end
      end
      ST_PHASE:  cmd.phase_mul = 1'b1;
      ST_LOOKUP: cmd.lookup    = 1'b1;
      ST_AMP:    cmd.amp_mul   = 1'b1;
      ST_SINE_SUM: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_SINE;
      end
      ST_TRAP: begin
        if (stat.trap_flat) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PEAK;
        end else begin
          cmd.trap_mul = 1'b1;
        end
      end
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_WAIT: begin
        cmd.res_load = stat.div_done;
        cmd.res_sel  = RES_TRAP;
      end
      ST_WRITE: cmd.out_load = stat.out_free;
      default: begin
      end
    endcase
  end

endmodule

>>> sv/ppsg_checker.sv
// Port-level assertion checker for the setpoint generator, bound to the top level.
`include "pressure_profile_setpoint_generator_unit_defines.svh"

module ppsg_checker import ppsg_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  `PPSG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `PPSG_ASSERT_SAME(a_fin_zero, out_tvalid && out_tuser, out_tdata == 16'd0, "finished result is not zero")
  `PPSG_ASSERT_NEXT(a_start_silent, in_tvalid && in_tready && in_tuser == ACT_START && !out_tvalid, !out_tvalid, "start item produced a result")
  `PPSG_ASSERT_NEXT(a_sample_busy, in_tvalid && in_tready && in_tuser == ACT_SAMPLE, !in_tready, "item taken while a sample is in work")

endmodule

bind pressure_profile_setpoint_generator_unit ppsg_checker u_ppsg_checker (.*);

>>> dv/pressure_profile_setpoint_generator_unit_test.sv
// Self-checking testbench of the pressure setpoint generator: directed table, then random profile runs.
module pressure_profile_setpoint_generator_unit_test import ppsg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int NUM_PHASES = 20;
  localparam int PHASE_ITEMS = 72;

  typedef struct packed {
    logic        is_reg;
    reg_idx_t    sel;
    logic        act;
    logic [31:0] word;
    logic        known;
    logic [15:0] tgt;
    logic        fin;
  } script_row_t;

  localparam int SCRIPT_LEN = 42;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'h0000_0000,         1'b1, 16'h0000, 1'b1},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'hFFFF_FFFF,         1'b1, 16'h0000, 1'b1},
    '{1'b0, REG_MODE,      ACT_START,  32'h0000_0000,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'h0000_0005,         1'b1, 16'h0000, 1'b1},
    '{1'b1, REG_RUN_LEN,   ACT_START,  32'hFFFF_FFFF,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_LEVEL,     ACT_START,  32'h0000_7FFF,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_START,  32'hFFFF_FFF0,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'hFFFF_FFF0,         1'b1, 16'h7FFF, 1'b0},
    '{1'b1, REG_LEVEL,     ACT_START,  32'hFFFF_8000,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'h0000_0020,         1'b1, 16'h8000, 1'b0},
    '{1'b1, REG_MODE,      ACT_START,  {30'd0, MODE_SPARE},   1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'h0000_0030,         1'b1, 16'h0000, 1'b0},
    '{1'b1, REG_MODE,      ACT_START,  {30'd0, MODE_SINE},    1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_AMPLITUDE, ACT_START,  32'h0000_7FFF,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_PHASE,     ACT_START,  32'h4000_0000,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_LEVEL,     ACT_START,  32'h0000_0000,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'hFFFF_FFF0,         1'b1, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'hFFFF_FFF1,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'hFFFF_FFF2,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'hFFFF_FFF3,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_AMPLITUDE, ACT_START,  32'h0000_8000,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_LEVEL,     ACT_START,  32'h0000_7FFF,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'hFFFF_FFF3,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_PHASE,     ACT_START,  32'hFFFF_FFFF,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'h0000_0005,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_MODE,      ACT_START,  {30'd0, MODE_TRAP},    1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_PEAK,      ACT_START,  32'hFFFF_FFFF,         1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_RAMP,      ACT_START,  32'd100,               1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_HOLD,      ACT_START,  32'd50,                1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_START,  32'd1000,              1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd1050,              1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd1100,              1'b1, 16'h7FFF, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd1150,              1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd1650,              1'b1, 16'h8000, 1'b0},
    '{1'b1, REG_RAMP,      ACT_START,  32'd0,                 1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd1001,              1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd5000,              1'b1, 16'h7FFF, 1'b0},
    '{1'b1, REG_RUN_LEN,   ACT_START,  32'd10,                1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd1020,              1'b1, 16'h0000, 1'b1},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'd1005,              1'b1, 16'h0000, 1'b1},
    '{1'b0, REG_MODE,      ACT_START,  32'hFFFF_FFFB,         1'b0, 16'h0000, 1'b0},
    '{1'b0, REG_MODE,      ACT_SAMPLE, 32'h0000_0004,         1'b0, 16'h0000, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;    // [31:0] now_ms
  logic              in_tuser = 1'b0;  // [0] action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;        // [15:0] target
  logic              out_tuser;        // [0] finished
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  logic [1:0]         prof_mode = MODE_LEVEL;
  logic [31:0]        prof_run_len = '0;
  logic signed [15:0] prof_amp = '0;
  logic [31:0]        prof_step = '0;
  logic signed [15:0] prof_level = '0;
  logic [14:0]        prof_peak = '0;
  logic [31:0]        prof_ramp = '0;
  logic [31:0]        prof_hold = '0;
  logic [31:0]        run_t0 = '0;
  logic               run_done = 1'b1;
  int                 quarter_wave [QTAB_LEN];

  logic [15:0] want_target [$];
  logic        want_finished [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          stall_style = 0;
  int          style_left = 0;
  int          stall_left = 0;

  pressure_profile_setpoint_generator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void build_quarter_wave();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          acc;
    bit              neg;
    for (int i = 0; i < QTAB_LEN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      neg  = 1'b1;
      for (int k = 3; k <= 11; k += 2) begin
        term = ((term * x2) >> 30) / 64'((k - 1) * k);
        acc  = neg ? acc - longint'(term) : acc + longint'(term);
        neg  = !neg;
      end
      if (acc < 0) begin
        acc = 0;
      end
      r = ($unsigned(acc) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      quarter_wave[i] = int'(r);
    end
  endfunction

  function automatic logic [15:0] clamp_q78(input longint v);
    if (v > 32767) begin
      return 16'h7FFF;
    end
    if (v < -32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [15:0] sine_point(input logic [31:0] el);
    logic [31:0] ph;
    int          idx;
    longint      s;
    longint      prod;
    ph  = prof_step * el;
    idx = int'(ph[29 -: SINE_TABLE_BITS]);
    if (ph[30]) begin
      idx = QTAB_LEN - 1 - idx;
    end
    s = longint'(quarter_wave[idx]);
    if (ph[31]) begin
      s = -s;
    end
    prod = longint'(prof_amp) * s;
    return clamp_q78(((prod + 64'sd16384) >>> 15) + longint'(prof_level));
  endfunction

  function automatic logic [15:0] trap_point(input logic [31:0] el);
    longint unsigned pk;
    longint unsigned fall_at;
    longint unsigned drop;
    pk      = 64'(prof_peak);
    fall_at = 64'(prof_ramp) + 64'(prof_hold);
    if (el < prof_ramp) begin
      return clamp_q78(longint'((pk * 64'(el)) / 64'(prof_ramp)));
    end
    if (64'(el) < fall_at || prof_ramp == 32'd0) begin
      return clamp_q78(longint'(pk));
    end
    drop = (pk * (64'(el) - fall_at)) / 64'(prof_ramp);
    return clamp_q78(longint'(pk) - longint'(drop));
  endfunction

  function automatic bit predict_setpoint(input logic act, input logic [31:0] now,
                                          output logic [15:0] tgt, output logic fin);
    logic [31:0] el;
    tgt = '0;
    fin = 1'b0;
    if (act == ACT_START) begin
      run_t0   = now;
      run_done = 1'b0;
      return 1'b0;
    end
    el = now - run_t0;
    if (run_done || el >= prof_run_len) begin
      run_done = 1'b1;
      fin      = 1'b1;
    end else begin
      case (prof_mode)
        MODE_SINE:  tgt = sine_point(el);
        MODE_TRAP:  tgt = trap_point(el);
        MODE_LEVEL: tgt = prof_level;
        default:    tgt = '0;
      endcase
    end
    return 1'b1;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODE:      prof_mode = val[1:0];
      REG_RUN_LEN:   prof_run_len = val;
      REG_AMPLITUDE: prof_amp = val[15:0];
      REG_PHASE:     prof_step = val;
      REG_LEVEL:     prof_level = val[15:0];
      REG_PEAK:      prof_peak = val[14:0];
      REG_RAMP:      prof_ramp = val;
      REG_HOLD:      prof_hold = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_item(input logic act, input logic [31:0] now, input logic known,
                           input logic [15:0] tgt_known, input logic fin_known);
    logic [15:0] tgt;
    logic        fin;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= now;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_setpoint(act, now, tgt, fin)) begin
      if (known) begin
        tgt = tgt_known;
        fin = fin_known;
      end
      want_target.push_back(tgt);
      want_finished.push_back(fin);
    end
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic drain_to_idle();
    in_tvalid <= 1'b0;
    while (want_target.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_profile(input int ph);
    logic [1:0]  m;
    logic [31:0] ramp_w;
    logic [31:0] hold_w;
    logic [31:0] run_w;
    longint      span;
    if (ph < 4) begin
      m = 2'(ph);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: m = MODE_SINE;
        4, 5, 6, 7: m = MODE_TRAP;
        8:          m = MODE_LEVEL;
        default:    m = MODE_SPARE;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       ramp_w = 32'd0;
      1:       ramp_w = 32'hFFFF_FFFF;
      2:       ramp_w = $urandom();
      default: ramp_w = $urandom_range(1, 500);
    endcase
    case ($urandom_range(0, 9))
      0:       hold_w = 32'd0;
      1:       hold_w = 32'hFFFF_FFFF;
      2:       hold_w = $urandom();
      default: hold_w = $urandom_range(0, 500);
    endcase
    case ($urandom_range(0, 11))
      0:       run_w = 32'd0;
      1:       run_w = 32'hFFFF_FFFF;
      2:       run_w = $urandom();
      default: begin
        span = 2 * longint'(ramp_w) + longint'(hold_w) + longint'($urandom_range(0, 200));
        run_w = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      end
    endcase
    write_reg(REG_MODE, ($urandom() & 32'hFFFF_FFFC) | {30'd0, m});
    write_reg(REG_RUN_LEN, run_w);
    case ($urandom_range(0, 5))
      0:       write_reg(REG_AMPLITUDE, {16'($urandom_range(0, 65535)), 16'h7FFF});
      1:       write_reg(REG_AMPLITUDE, {16'($urandom_range(0, 65535)), 16'h8000});
      default: write_reg(REG_AMPLITUDE, $urandom());
    endcase
    case ($urandom_range(0, 6))
      0:       write_reg(REG_PHASE, 32'd0);
      1:       write_reg(REG_PHASE, 32'hFFFF_FFFF);
      2, 3:    write_reg(REG_PHASE, $urandom_range(0, 1 << 24));
      default: write_reg(REG_PHASE, $urandom());
    endcase
    case ($urandom_range(0, 6))
      0:       write_reg(REG_LEVEL, 32'h0000_7FFF);
      1:       write_reg(REG_LEVEL, 32'hFFFF_8000);
      2, 3:    write_reg(REG_LEVEL, 32'($urandom_range(0, 4000)) - 32'd2000);
      default: write_reg(REG_LEVEL, $urandom());
    endcase
    case ($urandom_range(0, 6))
      0:       write_reg(REG_PEAK, 32'd0);
      1:       write_reg(REG_PEAK, 32'h0000_7FFF);
      2:       write_reg(REG_PEAK, 32'h0000_FFFF);
      default: write_reg(REG_PEAK, $urandom());
    endcase
    write_reg(REG_RAMP, ramp_w);
    write_reg(REG_HOLD, hold_w);
  endtask

  task automatic run_profile(input int n_items);
    logic [31:0] base;
    logic [31:0] el;
    logic [31:0] last_el;
    longint      hz;
    base    = run_t0;
    last_el = '0;
    for (int k = 0; k < n_items; k++) begin
      hz = 2 * longint'(prof_ramp) + longint'(prof_hold) + 40;
      if (hz > longint'(prof_run_len) + 40) begin
        hz = longint'(prof_run_len) + 40;
      end
      if (hz > 64'hFFFF_FFFF) begin
        hz = 64'hFFFF_FFFF;
      end
      if ((run_done && $urandom_range(0, 3) != 0) || $urandom_range(0, 24) == 0) begin
        push_item(ACT_START, $urandom(), 1'b0, '0, 1'b0);
        last_el = '0;
      end else if ($urandom_range(0, 19) == 0) begin
        push_item(1'($urandom_range(0, 1)), $urandom(), 1'b0, '0, 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          5: begin
            case ($urandom_range(0, 5))
              0:       el = prof_ramp - 32'd1;
              1:       el = prof_ramp;
              2:       el = prof_ramp + prof_hold - 32'd1;
              3:       el = prof_ramp + prof_hold;
              4:       el = prof_run_len - 32'd1;
              default: el = prof_run_len;
            endcase
          end
          6:       el = prof_run_len + $urandom_range(0, 100);
          7:       el = $urandom();
          8, 9:    el = last_el + $urandom_range(1, 20);
          default: el = $urandom_range(0, 32'(hz));
        endcase
        last_el = el;
        push_item(ACT_SAMPLE, base + el, 1'b0, '0, 1'b0);
      end
      base = run_t0;
      pace_sender();
    end
  endtask

  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(50, 400);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left != 0) begin
          out_tready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(5, 40);
          end
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (want_target.size() == 0) begin
        $error("result with no sample pending: target %h finished %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        if (out_tdata !== want_target[0]) begin
          $error("target: expected %h, got %h", want_target[0], out_tdata);
          mismatches++;
        end
        if (out_tuser !== want_finished[0]) begin
          $error("finished: expected %b, got %b", want_finished[0], out_tuser);
          mismatches++;
        end
        void'(want_target.pop_front());
        void'(want_finished.pop_front());
      end
    end
  end

  initial begin
    build_quarter_wave();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].is_reg) begin
        drain_to_idle();
        write_reg(SCRIPT[r].sel, SCRIPT[r].word);
      end else begin
        push_item(SCRIPT[r].act, SCRIPT[r].word, SCRIPT[r].known, SCRIPT[r].tgt,
                  SCRIPT[r].fin);
        pace_sender();
      end
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_to_idle();
      load_profile(ph);
      run_profile(PHASE_ITEMS);
    end
    drain_to_idle();
    if (mismatches == 0 && want_target.size() == 0) begin
      $display("** pressure_profile_setpoint_generator_unit: PASSED **");
    end else begin
      $display("** pressure_profile_setpoint_generator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** pressure_profile_setpoint_generator_unit: FAILED **");
    $finish;
  end

endmodule
